>>> design/pgma_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the gradient core.
`timescale 1ns / 1ps
package pgma_pkg;

  localparam int CORDIC_STEPS = 21;
  localparam int STEP_W       = 5;
  localparam int ATAN_W       = 22;
  localparam int Z_W          = 26;
  localparam int MAG_W        = 13;
  localparam int ANG_W        = 13;
  localparam int ANGLE_MAX    = 2880;
  localparam int MAG_MAX      = 8191;
  localparam int DEG_180_Z    = 180 * 65536;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 12;
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // What a queued request asks of the back end
  typedef struct packed {
    logic first;   // result for the row above
    logic calc;    // interior pixel, run the gradient math
    logic second;  // extra zero result on the last row
    logic fend;    // second result is the frame's last pixel
  } pgma_kind_t;

  typedef enum logic [0:0] {F_IDLE, F_READ} front_state_e;
  typedef enum logic [1:0] {B_IDLE, B_CALC, B_OUT1, B_OUT2} back_state_e;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/pgma_in_if.sv
// Sample input channel.
`timescale 1ns / 1ps
interface pgma_in_if #(parameter int SAMPLE_BITS = 12) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   frame_start;
  modport source(output valid, sample, frame_start, input ready);
  modport sink(input valid, sample, frame_start, output ready);
endinterface

>>> design/pgma_out_if.sv
// Result output channel.
`timescale 1ns / 1ps
interface pgma_out_if ();
  logic               valid;
  logic               ready;
  logic [12:0]        magnitude;
  logic signed [12:0] angle;
  logic               last_of_run;
  logic               frame_end;
  modport source(output valid, magnitude, angle, last_of_run, frame_end, input ready);
  modport sink(input valid, magnitude, angle, last_of_run, frame_end, output ready);
endinterface

>>> design/pgma_front.sv
// Front end: position counters, line stores, central differences, request classification.
`timescale 1ns / 1ps
module pgma_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pgma_pkg::WIDTH_W-1:0]      width_i,
  input  logic [pgma_pkg::HEIGHT_W-1:0]     height_i,
  pgma_in_if.sink                           in_i,
  output logic                              push_o,
  output logic signed [SAMPLE_BITS:0]       push_gx_o,
  output logic signed [SAMPLE_BITS:0]       push_gy_o,
  output pgma_pkg::pgma_kind_t              push_kind_o,
  input  logic                              full_i
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [SAMPLE_BITS-1:0] row_above_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] row_two_mem   [MAX_WIDTH];

  pgma_pkg::front_state_e state_q, state_d;
  logic [AW-1:0]                    col_q, c_q;
  logic [pgma_pkg::HEIGHT_W-1:0]    row_q;
  logic [SAMPLE_BITS-1:0]           s_q, mid_q, top_q, right_q, left_above_q;
  logic                             right_ok_q;
  pgma_pkg::pgma_kind_t             kind_q, kind_now;

  logic [31:0] w32, h32, c32, r32;
  logic        accept, done, right_ok_now;
  logic [AW-1:0] c_addr, c_next_addr;
  logic [SAMPLE_BITS-1:0] right_val;

  // Clamped frame geometry and current position
  always_comb begin
    if (width_i < 11'd3) w32 = 32'd3;
    else if (32'(width_i) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else w32 = 32'(width_i);
    h32 = (height_i < 12'd3) ? 32'd3 : 32'(height_i);
    if (in_i.frame_start) begin
      c32 = '0;
      r32 = '0;
    end else begin
      c32 = (32'(col_q) < w32) ? 32'(col_q) : w32 - 32'd1;
      r32 = (32'(row_q) < h32) ? 32'(row_q) : h32 - 32'd1;
    end
    c_addr        = AW'(c32);
    c_next_addr   = AW'(c32 + 32'd1);
    right_ok_now  = (c32 + 32'd1) < w32;
    kind_now.first  = r32 >= 32'd1;
    kind_now.calc   = (r32 >= 32'd2) && (c32 >= 32'd1) && right_ok_now;
    kind_now.second = r32 == h32 - 32'd1;
    kind_now.fend   = (r32 == h32 - 32'd1) && (c32 == w32 - 32'd1);
  end

  assign in_i.ready = (state_q == pgma_pkg::F_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Request to the queue once the line store words are back
  assign right_val = right_ok_q ? right_q : '0;
  assign push_gx_o = $signed({1'b0, right_val}) - $signed({1'b0, left_above_q});
  assign push_gy_o = $signed({1'b0, s_q}) - $signed({1'b0, top_q});
  assign push_kind_o = kind_q;
  assign push_o = (state_q == pgma_pkg::F_READ) && kind_q.first && !full_i;
  assign done   = (state_q == pgma_pkg::F_READ) && (!kind_q.first || !full_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pgma_pkg::F_IDLE: if (accept) state_d = pgma_pkg::F_READ;
      pgma_pkg::F_READ: if (done) state_d = pgma_pkg::F_IDLE;
      default: state_d = pgma_pkg::F_IDLE;
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pgma_pkg::F_IDLE;
      col_q        <= '0;
      row_q        <= '0;
      left_above_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (right_ok_now) begin
          col_q <= AW'(c32 + 32'd1);
          row_q <= pgma_pkg::HEIGHT_W'(r32);
        end else begin
          col_q <= '0;
          row_q <= ((r32 + 32'd1) < h32) ? pgma_pkg::HEIGHT_W'(r32 + 32'd1) : '0;
        end
      end
      if (done) left_above_q <= mid_q;
    end
  end

  // Line stores with registered reads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_q      <= row_above_mem[c_addr];
      right_q    <= row_above_mem[c_next_addr];
      top_q      <= row_two_mem[c_addr];
      c_q        <= c_addr;
      s_q        <= in_i.sample;
      right_ok_q <= right_ok_now;
      kind_q     <= kind_now;
    end
    if (done) begin
      row_two_mem[c_q]   <= mid_q;
      row_above_mem[c_q] <= s_q;
    end
  end

endmodule

>>> design/pgma_queue.sv
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
module pgma_queue #(
  parameter int DW = 30
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o,
  output logic          empty_o,
  output logic          full_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign empty_o    = (cnt_q == 2'd0);
  assign full_o     = (cnt_q == 2'd2);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

>>> design/pgma_back.sv
// Back end: iterative square root and CORDIC vectoring, result sequencing.
`timescale 1ns / 1ps
module pgma_back #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  logic signed [SAMPLE_BITS:0] gx_i,
  input  logic signed [SAMPLE_BITS:0] gy_i,
  input  pgma_pkg::pgma_kind_t        kind_i,
  output logic                        pop_o,
  pgma_out_if.source                  out_o
);

  localparam int CW  = SAMPLE_BITS + 19;
  localparam int SQW = 2 * SAMPLE_BITS + 2;
  localparam int ZW  = pgma_pkg::Z_W;

  pgma_pkg::back_state_e state_q, state_d;
  pgma_pkg::pgma_kind_t  kind_q;
  logic signed [CW-1:0]  x_q, y_q, xs, ys, gx_ext, gy_ext;
  logic signed [ZW-1:0]  z_q, z_abs, atan_ext;
  logic [SQW-1:0]        rem_q, root_q, bit_q, trial, sq;
  logic [pgma_pkg::STEP_W-1:0] step_q;
  logic                  zero_q, slot_free, load1, load2;
  logic [ZW-1:0]         q_abs;
  logic [12:0]           ang_mag, mag_val;
  logic signed [12:0]    ang_val;
  logic signed [2*SAMPLE_BITS+1:0] sq_s;

  assign slot_free = !out_o.valid || out_o.ready;
  assign pop_o     = (state_q == pgma_pkg::B_IDLE) && !empty_i;
  assign load1     = (state_q == pgma_pkg::B_OUT1) && slot_free;
  assign load2     = (state_q == pgma_pkg::B_OUT2) && slot_free;

  // Operand setup: widened components and squared length; the turn into the right half plane is at load
  always_comb begin
    gx_ext = CW'(gx_i);
    gy_ext = CW'(gy_i);
    sq_s   = (2*SAMPLE_BITS+2)'(gx_i * gx_i) + (2*SAMPLE_BITS+2)'(gy_i * gy_i);
    sq     = SQW'(sq_s);
  end

  // One CORDIC step, shifts truncating toward zero, and the square-root trial value
  always_comb begin
    xs = x_q[CW-1] ? -((-x_q) >>> step_q) : (x_q >>> step_q);
    ys = y_q[CW-1] ? -((-y_q) >>> step_q) : (y_q >>> step_q);
    atan_ext = ZW'($signed({1'b0, pgma_pkg::atan_lut(step_q)}));
    trial = root_q + bit_q;
  end

  // Angle rounding to 1/16 degree, halves away from zero, and clamp of angle and magnitude
  always_comb begin
    z_abs = z_q[ZW-1] ? -z_q : z_q;
    q_abs = ZW'((z_abs + ZW'(2048)) >>> 12);
    ang_mag = (q_abs > ZW'(pgma_pkg::ANGLE_MAX)) ? 13'(pgma_pkg::ANGLE_MAX) : q_abs[12:0];
    if (zero_q) ang_val = '0;
    else ang_val = z_q[ZW-1] ? -$signed(ang_mag) : $signed(ang_mag);
    mag_val = (root_q > SQW'(pgma_pkg::MAG_MAX)) ? 13'(pgma_pkg::MAG_MAX) : root_q[12:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pgma_pkg::B_IDLE: begin
        if (!empty_i) begin
          if (kind_i.calc) state_d = pgma_pkg::B_CALC;
          else if (kind_i.first) state_d = pgma_pkg::B_OUT1;
          else state_d = pgma_pkg::B_OUT2;
        end
      end
      pgma_pkg::B_CALC: begin
        if (step_q == pgma_pkg::STEP_W'(pgma_pkg::CORDIC_STEPS - 1)) state_d = pgma_pkg::B_OUT1;
      end
      pgma_pkg::B_OUT1: begin
        if (slot_free) state_d = kind_q.second ? pgma_pkg::B_OUT2 : pgma_pkg::B_IDLE;
      end
      pgma_pkg::B_OUT2: if (slot_free) state_d = pgma_pkg::B_IDLE;
      default: state_d = pgma_pkg::B_IDLE;
    endcase
  end

  // Control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pgma_pkg::B_IDLE;
      out_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load1 || load2) out_o.valid <= 1'b1;
      else if (out_o.ready) out_o.valid <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= kind_i;
      step_q <= '0;
      rem_q  <= sq;
      root_q <= '0;
      bit_q  <= SQW'(1) << (SQW - 2);
      zero_q <= (gx_i == '0) && (gy_i == '0);
      z_q    <= '0;
      if (gx_i[SAMPLE_BITS]) begin
        x_q <= -(gx_ext <<< 16);
        y_q <= -(gy_ext <<< 16);
        z_q <= gy_i[SAMPLE_BITS] ? -ZW'(pgma_pkg::DEG_180_Z) : ZW'(pgma_pkg::DEG_180_Z);
      end else begin
        x_q <= gx_ext <<< 16;
        y_q <= gy_ext <<< 16;
      end
    end else if (state_q == pgma_pkg::B_CALC) begin
      step_q <= step_q + pgma_pkg::STEP_W'(1);
      if (!y_q[CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_ext;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_ext;
      end
      // square root, two bits of radicand per step
      if (bit_q != '0) begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
    if (load1) begin
      out_o.magnitude   <= kind_q.calc ? mag_val : '0;
      out_o.angle       <= kind_q.calc ? ang_val : '0;
      out_o.last_of_run <= !kind_q.second;
      out_o.frame_end   <= 1'b0;
    end else if (load2) begin
      out_o.magnitude   <= '0;
      out_o.angle       <= '0;
      out_o.last_of_run <= 1'b1;
      out_o.frame_end   <= kind_q.fend;
    end
  end

endmodule

>>> design/pixel_gradient_magnitude_angle_core.sv
// Top level of the HOG central-difference gradient core.
// Front end takes a sample, reads the line stores, then writes them back before it takes
// the next one; it waits while a request is due and the queue is full. An interior pixel
// runs the back end through 21 CORDIC/square-root steps, then one output (one more on the
// last row); border results skip the steps. Throughput is set by the 21-step iterative
// CORDIC unit; the back end pops a new request only once the last one's results are out.
// Reset is asynchronous, active low; it clears counters, queue and valids, line stores
// keep their contents, and a word feeds a result only after it has been written.
`timescale 1ns / 1ps
module pixel_gradient_magnitude_angle_core #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pgma_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pgma_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pgma_in_if.sink                             in_i,
  pgma_out_if.source                          out_o
);

  localparam int DW = 2 * (SAMPLE_BITS + 1) + 4;

  logic [pgma_pkg::WIDTH_W-1:0]  width_q;
  logic [pgma_pkg::HEIGHT_W-1:0] height_q;

  logic                        push, pop, empty, full;
  logic signed [SAMPLE_BITS:0] push_gx, push_gy, pop_gx, pop_gy;
  pgma_pkg::pgma_kind_t        push_kind, pop_kind;
  logic [DW-1:0]               pop_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pgma_pkg::WIDTH_RESET;
      height_q <= pgma_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pgma_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[pgma_pkg::WIDTH_W-1:0];
        pgma_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pgma_front #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .width_i(width_q), .height_i(height_q),
    .in_i,
    .push_o(push), .push_gx_o(push_gx), .push_gy_o(push_gy),
    .push_kind_o(push_kind), .full_i(full)
  );

  pgma_queue #(.DW(DW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i({push_gx, push_gy, push_kind}),
    .pop_i(pop), .pop_data_o(pop_data),
    .empty_o(empty), .full_o(full)
  );

  assign {pop_gx, pop_gy, pop_kind} = pop_data;

  pgma_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .gx_i(pop_gx), .gy_i(pop_gy), .kind_i(pop_kind),
    .pop_o(pop), .out_o
  );

endmodule

>>> design/pgma_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module pgma_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic [12:0]        magnitude,
  input logic signed [12:0] angle,
  input logic               last_of_run,
  input logic               frame_end
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(angle))
    else $error("stalled result changed");

  // Frame end is a zero result closing its run
  a_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_end |-> last_of_run && magnitude == 13'd0 && angle == 13'sd0)
    else $error("bad frame end result");

  // Angle stays within half a turn
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> angle <= 13'sd2880 && angle >= -13'sd2880)
    else $error("angle out of range");

  // A zero-length vector has no direction
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && magnitude == 13'd0 |-> angle == 13'sd0)
    else $error("angle on zero magnitude");

endmodule

bind pixel_gradient_magnitude_angle_core pgma_checker u_pgma_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .magnitude(out_o.magnitude),
  .angle(out_o.angle),
  .last_of_run(out_o.last_of_run),
  .frame_end(out_o.frame_end)
);
